[design/tcce_pkg.sv]
// shared constants, types and codes of the text console character engine
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 4;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CELL_W     = 16;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int PH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int PH_LAST    = (COLUMNS - 1) % TAB_STOP;

  localparam logic [7:0] RESET_COLOR  = 8'h07;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam int REG_FILL_COLOR = 0;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_W:0]    rowx_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PH_W-1:0]   ph_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [1:0] {
    K_PUT   = 2'd0,
    K_CLEAR = 2'd1,
    K_READ  = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

endpackage

[design/text_console_character_engine_unit.sv]
// text console: screen store in one ram, cursor, scroll by rotating row offset
// each word passes S_EXEC then S_DONE; a read in range also S_RDWAIT, a backspace
// S_BSWR; a tab puts one space a cycle in S_EXEC to its stop; a scroll fills COLUMNS
// cells, a clear CELL_COUNT, both by the single ram write port (one cell a cycle)
// in_ready is high only in S_IDLE: a new word waits until the last has left S_DONE
// reset: synchronous; a sweep of all CELL_COUNT cells fills the screen with spaces in
// colour 0x07 while in_ready stays low; register writes are taken throughout
module text_console_character_engine_unit
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_character,
  input  logic [7:0]  in_color,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_color,
  output logic [4:0]  out_cursor_row_now,
  output logic [6:0]  out_cursor_col_now,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_BSWR, S_RDWAIT, S_FILL, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [4:0]  rrow_r, rrow_nxt;
  logic [6:0]  rcol_r, rcol_nxt;
  row_t        cur_row_r, cur_row_nxt;
  col_t        cur_col_r, cur_col_nxt;
  ph_t         ph_r, ph_nxt;
  row_t        top_r, top_nxt;
  addr_t       fill_addr_r, fill_addr_nxt;
  addr_t       fill_last_r, fill_last_nxt;
  cell_t       fill_data_r, fill_data_nxt;
  logic [7:0]  res_char_r, res_char_nxt;
  logic [7:0]  res_color_r, res_color_nxt;
  logic [7:0]  fill_color_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic [7:0]  out_color_r, out_color_nxt;
  logic [4:0]  out_row_r, out_row_nxt;
  logic [6:0]  out_col_r, out_col_nxt;

  logic        ram_we, ram_re;
  addr_t       ram_waddr, ram_raddr;
  cell_t       ram_wdata, ram_rdata;
  addr_t       cur_addr;
  addr_t       top_base;
  ph_t         ph_inc;
  logic        do_nl;
  logic        rd_in_range;
  logic        cfg_wr;

  // logical row is rotated by the top row offset, so a scroll moves no data
  function automatic addr_t addr_of(row_t lrow, row_t top, col_t col);
    rowx_t p;
    p = {1'b0, lrow} + {1'b0, top};
    if (p >= rowx_t'(ROWS)) begin
      p = p - rowx_t'(ROWS);
    end
    return addr_t'(addr_t'(p[ROW_W-1:0]) * addr_t'(COLUMNS)) + addr_t'(col);
  endfunction

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_FILL_COLOR));
  assign prdata = (paddr[2] == 1'(REG_FILL_COLOR)) ? {24'd0, fill_color_r} : 32'd0;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_color     = out_color_r;
  assign out_cursor_row_now = out_row_r;
  assign out_cursor_col_now = out_col_r;

  assign cur_addr    = addr_of(cur_row_r, top_r, cur_col_r);
  assign ram_raddr   = addr_of(row_t'(rrow_r), top_r, col_t'(rcol_r));
  assign top_base    = addr_t'(addr_t'(top_r) * addr_t'(COLUMNS));
  assign ph_inc      = (ph_r == ph_t'(TAB_STOP - 1)) ? '0 : ph_r + 1'b1;
  assign rd_in_range = (int'(rrow_r) < ROWS) && (int'(rcol_r) < COLUMNS);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    color_nxt     = color_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    ph_nxt        = ph_r;
    top_nxt       = top_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_data_nxt = fill_data_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_color_nxt = out_color_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_addr_r;
    ram_wdata     = fill_data_r;
    ram_re        = 1'b0;
    do_nl         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT, S_FILL: begin
        ram_we = 1'b1;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt      = kind_t'(in_kind);
          ch_nxt        = in_character;
          color_nxt     = in_color;
          rrow_nxt      = in_read_row;
          rcol_nxt      = in_read_col;
          res_char_nxt  = 8'd0;
          res_color_nxt = 8'd0;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (kind_r)
          K_PUT: begin
            priority if (ch_r == CH_NEWLINE) begin
              do_nl = 1'b1;
            end else if (ch_r == CH_BACKSPACE) begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - 1'b1;
                ph_nxt      = (ph_r == '0) ? ph_t'(TAB_STOP - 1) : ph_r - 1'b1;
              end else if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - 1'b1;
                cur_col_nxt = col_t'(COLUMNS - 1);
                ph_nxt      = ph_t'(PH_LAST);
              end
              state_nxt = S_BSWR;
            end else begin
              // printable byte, or one space of a tab; a tab stays here until its stop
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {color_r, (ch_r == CH_TAB) ? CH_SPACE : ch_r};
              if (cur_col_r == col_t'(COLUMNS - 1)) begin
                do_nl = 1'b1;
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
                ph_nxt      = ph_inc;
                state_nxt   = ((ch_r == CH_TAB) && (ph_inc != '0)) ? S_EXEC : S_DONE;
              end
            end
          end
          K_CLEAR: begin
            cur_row_nxt   = '0;
            cur_col_nxt   = '0;
            ph_nxt        = '0;
            top_nxt       = '0;
            fill_addr_nxt = '0;
            fill_last_nxt = addr_t'(CELL_COUNT - 1);
            fill_data_nxt = {color_r, CH_SPACE};
            state_nxt     = S_FILL;
          end
          K_READ: begin
            if (rd_in_range) begin
              ram_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase

        if (do_nl) begin
          cur_col_nxt = '0;
          ph_nxt      = '0;
          if (cur_row_r == row_t'(ROWS - 1)) begin
            // old top row becomes the blank bottom row
            top_nxt       = (top_r == row_t'(ROWS - 1)) ? '0 : top_r + 1'b1;
            fill_addr_nxt = top_base;
            fill_last_nxt = top_base + addr_t'(COLUMNS - 1);
            fill_data_nxt = {fill_color_r, CH_SPACE};
            state_nxt     = S_FILL;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_BSWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {color_r, CH_SPACE};
        state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        res_char_nxt  = ram_rdata[7:0];
        res_color_nxt = ram_rdata[15:8];
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = res_char_r;
          out_color_nxt = res_color_r;
          out_row_nxt   = 5'(cur_row_r);
          out_col_nxt   = 7'(cur_col_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      ph_r         <= '0;
      top_r        <= '0;
      fill_addr_r  <= '0;
      fill_last_r  <= addr_t'(CELL_COUNT - 1);
      fill_data_r  <= {RESET_COLOR, CH_SPACE};
      fill_color_r <= RESET_COLOR;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      ph_r        <= ph_nxt;
      top_r       <= top_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_data_r <= fill_data_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        fill_color_r <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    ch_r        <= ch_nxt;
    color_r     <= color_nxt;
    rrow_r      <= rrow_nxt;
    rcol_r      <= rcol_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    out_char_r  <= out_char_nxt;
    out_color_r <= out_color_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_col_r) < COLUMNS) && (int'(cur_row_r) < ROWS))
    else $error("cursor outside the screen");

  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(top_r) < ROWS)
    else $error("top row offset outside the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (int'(ram_waddr) < CELL_COUNT))
    else $error("screen write beyond the last cell");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new word taken while one is in progress");

endmodule

[design/tcce_ram.sv]
// generic simple dual-port ram with one write port and a registered read port
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
